// ----- rtl/assert_macros.svh -----
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, held off during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication check failed");
// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication check failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/fgap_pkg.sv -----
// Shared types and constants of the first-greater-after-pair search.
`default_nettype none
package fgap_pkg;
   localparam int POS_W    = 10;
   localparam int HEIGHT_W = 32;
   localparam int COUNT_W  = 11;
   localparam int RESULT_W = 11;
   localparam int QUEUE_DEPTH = 2;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   localparam logic signed [RESULT_W-1:0] RESULT_NONE = '1;

   // Classified command handed from the front to the back.
   typedef struct packed {
      logic                is_query;
      logic [POS_W-1:0]    load_index;
      logic [HEIGHT_W-1:0] load_height;
      logic [POS_W-1:0]    pos_lo;
      logic [POS_W-1:0]    pos_hi;
      logic                same;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LD_LEAF,
      ST_LD_RL,
      ST_LD_RR,
      ST_LD_WR,
      ST_Q_RA,
      ST_Q_RB,
      ST_Q_CMP,
      ST_S_RD,
      ST_S_CHK,
      ST_S_UP
   } back_state_type;
endpackage
`default_nettype wire

// ----- rtl/fgap_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module fgap_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ----- rtl/fgap_front.sv -----
// Front end: accepts items, orders the query pair and builds a command.
`default_nettype none
module fgap_front (
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_mode,
   input  wire logic [fgap_pkg::POS_W-1:0]    req_load_index,
   input  wire logic [fgap_pkg::HEIGHT_W-1:0] req_load_height,
   input  wire logic [fgap_pkg::POS_W-1:0]    req_query_first,
   input  wire logic [fgap_pkg::POS_W-1:0]    req_query_second,
   input  wire logic                          queue_full,
   input  wire logic                          clearing,
   output logic                               push,
   output fgap_pkg::cmd_type                  cmd
);
   import fgap_pkg::*;

   logic swap;

   assign busy = queue_full | clearing;
   assign push = start & ~busy;
   assign swap = req_query_first > req_query_second;

   always_comb begin
      cmd.is_query    = (req_mode == MODE_QUERY);
      cmd.load_index  = req_load_index;
      cmd.load_height = req_load_height;
      cmd.pos_lo      = swap ? req_query_second : req_query_first;
      cmd.pos_hi      = swap ? req_query_first : req_query_second;
      cmd.same        = (req_query_first == req_query_second);
   end
endmodule
`default_nettype wire

// ----- rtl/fgap_queue.sv -----
// Short command queue between the front and the back.
`default_nettype none
module fgap_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire fgap_pkg::cmd_type push_cmd,
   input  wire logic              pop,
   output fgap_pkg::cmd_type      head_cmd,
   output logic                   not_empty,
   output logic                   full
);
   import fgap_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   cmd_type          slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_cmd  = slots_ff[rd_ptr_ff];
   assign do_push   = push & ~full;
   assign do_pop    = pop & not_empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/fgap_back.sv -----
// Back end: clears the tree, applies loads and walks the tree for queries.
`default_nettype none
module fgap_back #(
   parameter int MAX_ELEMENTS = 1024
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 q_valid,
   input  wire fgap_pkg::cmd_type                    q_cmd,
   output logic                                      q_pop,
   input  wire logic [fgap_pkg::COUNT_W-1:0]         element_count,
   output logic                                      clearing,
   output logic                                      rsp_valid,
   output logic signed [fgap_pkg::RESULT_W-1:0]      rsp_result_index
);
   import fgap_pkg::*;

   localparam int DEPTH = 2 * MAX_ELEMENTS;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [AW-1:0] LEAF_BASE = AW'(MAX_ELEMENTS);
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

   back_state_type state_ff, state_in;
   logic [AW-1:0]       k_ff, k_in;
   logic [AW-1:0]       clr_ff, clr_in;
   cmd_type             cmd_ff, cmd_in;
   logic [HEIGHT_W-1:0] left_ff, left_in;
   logic [HEIGHT_W-1:0] ha_ff, ha_in;
   logic                desc_ff, desc_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RESULT_W-1:0] rsp_idx_ff, rsp_idx_in;

   logic                wr_en;
   logic [AW-1:0]       wr_addr, rd_addr;
   logic [HEIGHT_W-1:0] wr_data, rd_data, hb;
   logic                a_ok, b_ok, gt;
   logic [31:0]         start_pos, limit, found_pos;
   logic [AW-1:0]       found_node, sib;

   fgap_ram #(.WIDTH(HEIGHT_W), .DEPTH(DEPTH)) u_tree (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign a_ok      = 32'(cmd_ff.pos_lo) < 32'(MAX_ELEMENTS);
   assign b_ok      = 32'(cmd_ff.pos_hi) < 32'(MAX_ELEMENTS);
   assign hb        = b_ok ? rd_data : '0;
   assign start_pos = 32'(cmd_ff.pos_hi) + 32'd1;
   assign limit     = (32'(element_count) > 32'(MAX_ELEMENTS)) ?
                      32'(MAX_ELEMENTS) : 32'(element_count);
   assign gt        = rd_data > ha_ff;
   assign sib       = k_ff + 1'b1;
   // Taller node found: step into it, or into its right sibling when the
   // left child on the way down is not taller.
   assign found_node = gt ? k_ff : sib;
   assign found_pos = 32'(found_node - LEAF_BASE);

   assign clearing         = (state_ff == ST_CLEAR);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_index = rsp_idx_ff;

   // Next state and datapath registers.
   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      clr_in       = clr_ff;
      cmd_in       = cmd_ff;
      left_in      = left_ff;
      ha_in        = ha_ff;
      desc_in      = desc_ff;
      rsp_valid_in = 1'b0;
      rsp_idx_in   = rsp_idx_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               cmd_in = q_cmd;
               if (q_cmd.is_query) begin
                  state_in = ST_Q_RA;
               end else if (32'(q_cmd.load_index) < 32'(MAX_ELEMENTS)) begin
                  state_in = ST_LD_LEAF;
               end
            end
         end
         ST_LD_LEAF: begin
            k_in     = (LEAF_BASE + AW'(cmd_ff.load_index)) >> 1;
            state_in = ST_LD_RL;
         end
         ST_LD_RL: begin
            state_in = ST_LD_RR;
         end
         ST_LD_RR: begin
            left_in  = rd_data;
            state_in = ST_LD_WR;
         end
         ST_LD_WR: begin
            if (k_ff == AW'(1)) begin
               state_in = ST_IDLE;
            end else begin
               k_in     = k_ff >> 1;
               state_in = ST_LD_RL;
            end
         end
         ST_Q_RA: begin
            state_in = ST_Q_RB;
         end
         ST_Q_RB: begin
            ha_in    = a_ok ? rd_data : '0;
            state_in = ST_Q_CMP;
         end
         ST_Q_CMP: begin
            if (cmd_ff.same || ha_ff < hb) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = RESULT_W'(cmd_ff.pos_hi);
               state_in     = ST_IDLE;
            end else if (start_pos >= 32'(MAX_ELEMENTS)) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = RESULT_NONE;
               state_in     = ST_IDLE;
            end else begin
               k_in     = LEAF_BASE + AW'(start_pos);
               desc_in  = 1'b0;
               state_in = ST_S_RD;
            end
         end
         ST_S_RD: begin
            state_in = ST_S_CHK;
         end
         ST_S_CHK: begin
            if (gt || desc_ff) begin
               if (found_node >= LEAF_BASE) begin
                  rsp_valid_in = 1'b1;
                  rsp_idx_in   = (found_pos < limit) ? RESULT_W'(found_pos) : RESULT_NONE;
                  state_in     = ST_IDLE;
               end else begin
                  k_in     = found_node << 1;
                  desc_in  = 1'b1;
                  state_in = ST_S_RD;
               end
            end else if (!k_ff[0]) begin
               k_in     = sib;
               state_in = ST_S_RD;
            end else begin
               k_in     = k_ff >> 1;
               state_in = ST_S_UP;
            end
         end
         ST_S_UP: begin
            if (k_ff == AW'(1)) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = RESULT_NONE;
               state_in     = ST_IDLE;
            end else if (k_ff[0]) begin
               k_in = k_ff >> 1;
            end else begin
               k_in     = sib;
               state_in = ST_S_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Memory port and queue pop.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = k_ff;
      wr_data = '0;
      rd_addr = k_ff;
      q_pop   = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
         end
         ST_IDLE: begin
            q_pop = q_valid;
         end
         ST_LD_LEAF: begin
            wr_en   = 1'b1;
            wr_addr = LEAF_BASE + AW'(cmd_ff.load_index);
            wr_data = cmd_ff.load_height;
         end
         ST_LD_RL: begin
            rd_addr = k_ff << 1;
         end
         ST_LD_RR: begin
            rd_addr = (k_ff << 1) | AW'(1);
         end
         ST_LD_WR: begin
            wr_en   = 1'b1;
            wr_data = (left_ff > rd_data) ? left_ff : rd_data;
         end
         ST_Q_RA: begin
            rd_addr = a_ok ? LEAF_BASE + AW'(cmd_ff.pos_lo) : '0;
         end
         ST_Q_RB: begin
            rd_addr = b_ok ? LEAF_BASE + AW'(cmd_ff.pos_hi) : '0;
         end
         default: begin
            rd_addr = k_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff       <= k_in;
      cmd_ff     <= cmd_in;
      left_ff    <= left_in;
      ha_ff      <= ha_in;
      desc_ff    <= desc_in;
      rsp_idx_ff <= rsp_idx_in;
   end
endmodule
`default_nettype wire

// ----- rtl/first_greater_after_pair_search.sv -----
// Top level of the first-greater-after-pair search block.
//
// Usage: an item is transferred on a rising edge with start high and busy low.
// req_mode low loads req_load_height at req_load_index into a max tree kept
// in a 2*MAX_ELEMENTS word RAM; req_mode high asks a query on the pair
// req_query_first / req_query_second. Each query gives one transfer on the
// rsp_ side: rsp_valid is high for exactly one cycle with rsp_result_index
// (-1 when nothing is found). Loads give no transfer. The receiver cannot
// stall the block; results are never held.
// A front end classifies items into a two-entry queue; the back end works
// one command at a time through the single RAM read port (one read a cycle,
// registered). A load writes the leaf, then reads both children and writes
// their maximum at each tree level up to the root. A query is answered from
// the pair when it can be, otherwise by the climb and descent of the search.
// After reset the tree is cleared, one word a cycle, over all 2*MAX_ELEMENTS
// words (2048 at 1024) with busy high; csr_wr_en still writes element_count,
// which resets to 1024. MAX_ELEMENTS must be a power of two.
`default_nettype none
`include "assert_macros.svh"
module first_greater_after_pair_search #(
   parameter int MAX_ELEMENTS = 1024
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic                                 req_mode,
   input  wire logic [fgap_pkg::POS_W-1:0]           req_load_index,
   input  wire logic [fgap_pkg::HEIGHT_W-1:0]        req_load_height,
   input  wire logic [fgap_pkg::POS_W-1:0]           req_query_first,
   input  wire logic [fgap_pkg::POS_W-1:0]           req_query_second,
   output logic                                      rsp_valid,
   output logic signed [fgap_pkg::RESULT_W-1:0]      rsp_result_index,
   input  wire logic                                 csr_wr_en,
   input  wire logic [fgap_pkg::COUNT_W-1:0]         csr_wr_data
);
   import fgap_pkg::*;

   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1024);

   logic [COUNT_W-1:0] element_count_ff, element_count_in;
   cmd_type            push_cmd, head_cmd;
   logic               push, pop, q_full, q_not_empty, clearing;

   // Element count register: take csr_wr_data on every edge with csr_wr_en high.
   assign element_count_in = csr_wr_en ? csr_wr_data : element_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         element_count_ff <= COUNT_RESET;
      end else begin
         element_count_ff <= element_count_in;
      end
   end

   // Front: accept and classify.
   fgap_front u_front (
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_load_index   (req_load_index),
      .req_load_height  (req_load_height),
      .req_query_first  (req_query_first),
      .req_query_second (req_query_second),
      .queue_full       (q_full),
      .clearing         (clearing),
      .push             (push),
      .cmd              (push_cmd)
   );

   // Queue: decouple acceptance from tree work.
   fgap_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (pop),
      .head_cmd  (head_cmd),
      .not_empty (q_not_empty),
      .full      (q_full)
   );

   // Back: clear, load and search the tree.
   fgap_back #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_not_empty),
      .q_cmd            (head_cmd),
      .q_pop            (pop),
      .element_count    (element_count_ff),
      .clearing         (clearing),
      .rsp_valid        (rsp_valid),
      .rsp_result_index (rsp_result_index)
   );

   // No result may leave while the tree is still being cleared.
   `ASSERT_IMPLY(a_no_rsp_in_clear, clock, reset, clearing, !rsp_valid)
   // Every query passes through idle and its RAM reads before it answers, so strobes never abut.
   `ASSERT_NEXT(a_rsp_spaced, clock, reset, rsp_valid, !rsp_valid)
   // The back end only pops a queue that holds a command.
   `ASSERT_IMPLY(a_pop_nonempty, clock, reset, pop, q_not_empty)
endmodule
`default_nettype wire

// ----- dv/first_greater_after_pair_search_tb.sv -----
// Self-checking testbench for the first-greater-after-pair search block.
`timescale 1ns / 100ps
`default_nettype none
module first_greater_after_pair_search_tb;
   import fgap_pkg::*;

   localparam int NUM_POS    = 1024;
   localparam int CYCLE_CAP  = 1500000;
   localparam int DRAIN_WAIT = 200;

   typedef struct {
      logic                mode;
      logic [POS_W-1:0]    load_index;
      logic [HEIGHT_W-1:0] load_height;
      logic [POS_W-1:0]    query_first;
      logic [POS_W-1:0]    query_second;
   } request_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_mode = MODE_LOAD;
   logic [POS_W-1:0]    req_load_index = '0;
   logic [HEIGHT_W-1:0] req_load_height = '0;
   logic [POS_W-1:0]    req_query_first = '0;
   logic [POS_W-1:0]    req_query_second = '0;
   logic rsp_valid;
   logic signed [RESULT_W-1:0] rsp_result_index;
   logic csr_wr_en = 1'b0;
   logic [COUNT_W-1:0] csr_wr_data = '0;

   // Shadow of the heights and the count; the tree shape is not needed here.
   logic [HEIGHT_W-1:0] height_shadow [NUM_POS];
   logic [COUNT_W-1:0]  count_shadow;

   request_type pending_reqs [$];
   logic signed [RESULT_W-1:0] expected_answers [$];
   int  failures = 0;
   int  cycle_count = 0;
   int  burst_left = 0;
   int  gap_left = 0;
   bit  hold_for_drain = 1'b0;

   first_greater_after_pair_search i_dut (
      .clock, .reset, .start, .busy,
      .req_mode, .req_load_index, .req_load_height,
      .req_query_first, .req_query_second,
      .rsp_valid, .rsp_result_index,
      .csr_wr_en, .csr_wr_data
   );

   always #5 clock = ~clock;

   // Work out the answer of a query from the shadow store.
   function automatic logic signed [RESULT_W-1:0] pair_answer(logic [POS_W-1:0] p,
                                                             logic [POS_W-1:0] q);
      logic [POS_W-1:0] lo, hi;
      logic [HEIGHT_W-1:0] h_lo, h_hi, thr;
      int limit;
      lo = (p < q) ? p : q;
      hi = (p < q) ? q : p;
      h_lo = height_shadow[lo];
      h_hi = height_shadow[hi];
      if (lo == hi || h_lo < h_hi) return RESULT_W'(hi);
      thr = h_lo;
      limit = (count_shadow > NUM_POS) ? NUM_POS : int'(count_shadow);
      for (int k = int'(hi) + 1; k < limit; k++)
         if (height_shadow[k] > thr) return RESULT_W'(k);
      return RESULT_NONE;
   endfunction

   // Driver: hold the item until busy is low at an edge, then advance.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (start && !busy) begin
            // Transfer taken at this edge; predict from the accepted item.
            if (req_mode == MODE_LOAD)
               height_shadow[req_load_index] = req_load_height;
            else
               expected_answers.push_back(pair_answer(req_query_first, req_query_second));
         end
         if (!(start && busy)) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               start <= 1'b0;
            end else if (pending_reqs.size() == 0 || hold_for_drain) begin
               start <= 1'b0;
            end else begin
               request_type r;
               r = pending_reqs.pop_front();
               start <= 1'b1;
               req_mode <= r.mode;
               req_load_index <= r.load_index;
               req_load_height <= r.load_height;
               req_query_first <= r.query_first;
               req_query_second <= r.query_second;
               if (burst_left > 0) burst_left <= burst_left - 1;
               else begin
                  burst_left <= $urandom_range(20, 0);
                  gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
               end
            end
         end
      end
   end

   // Monitor: every strobe is one transfer; check it against the oldest answer.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_answers.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %0d",
                     $time, rsp_result_index);
            failures++;
         end else begin
            logic signed [RESULT_W-1:0] want;
            want = expected_answers.pop_front();
            if (rsp_result_index !== want) begin
               $display("%0t: result_index mismatch, expected %0d, actual %0d",
                        $time, want, rsp_result_index);
               failures++;
            end
         end
      end
      if (cycle_count > CYCLE_CAP) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic request_type make_load(int idx, logic [HEIGHT_W-1:0] h);
      request_type r;
      r.mode = MODE_LOAD;
      r.load_index = POS_W'(idx);
      r.load_height = h;
      r.query_first = POS_W'($urandom);
      r.query_second = POS_W'($urandom);
      return r;
   endfunction

   function automatic request_type make_query(int p, int q);
      request_type r;
      r.mode = MODE_QUERY;
      r.load_index = POS_W'($urandom);
      r.load_height = $urandom;
      r.query_first = POS_W'(p);
      r.query_second = POS_W'(q);
      return r;
   endfunction

   // Wait for the queue to empty and every answer to arrive, then let the
   // block finish any trailing load before touching the register.
   task automatic drain_all();
      hold_for_drain = 1'b0;
      wait (pending_reqs.size() == 0);
      @(posedge clock);
      wait (!start && !busy && expected_answers.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_count(logic [COUNT_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      count_shadow = value;
      csr_wr_en <= 1'b0;
   endtask

   // Mostly short random windows so the linear search stays cheap; a few
   // queries look far ahead with sparse taller heights.
   task automatic random_phase(int n, int span);
      int base;
      for (int i = 0; i < n; i++) begin
         base = $urandom_range(NUM_POS - 1, 0);
         case ($urandom_range(9, 0))
            0, 1, 2, 3:
               pending_reqs.push_back(make_load((base + $urandom_range(span, 0)) % NUM_POS,
                  ($urandom_range(7, 0) == 0) ? $urandom : $urandom_range(40, 1)));
            4:
               pending_reqs.push_back(make_load($urandom_range(NUM_POS - 1, 0),
                  ($urandom_range(1, 0)) ? 32'hFFFF_FFFF : 32'h0));
            default:
               pending_reqs.push_back(make_query(base,
                  (base + $urandom_range(span, 0)) % NUM_POS));
         endcase
      end
   endtask

   initial begin
      count_shadow = COUNT_W'(NUM_POS);
      foreach (height_shadow[k]) height_shadow[k] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero heights, same position, extremes of height and index.
      pending_reqs.push_back(make_query(5, 5));
      pending_reqs.push_back(make_query(0, 1023));
      pending_reqs.push_back(make_load(0, 32'hFFFF_FFFF));
      pending_reqs.push_back(make_load(1023, 32'h1));
      pending_reqs.push_back(make_load(10, 32'd7));
      pending_reqs.push_back(make_load(11, 32'd7));
      pending_reqs.push_back(make_load(12, 32'd8));
      pending_reqs.push_back(make_load(14, 32'd9));
      pending_reqs.push_back(make_query(11, 10));   // equal heights search on
      pending_reqs.push_back(make_query(10, 12));   // lower first gives second
      pending_reqs.push_back(make_query(12, 10));
      pending_reqs.push_back(make_query(0, 1));     // nothing taller: none
      pending_reqs.push_back(make_query(1022, 1023));
      pending_reqs.push_back(make_query(1023, 1023));
      pending_reqs.push_back(make_load(10, 32'h0)); // zero height stored as is
      pending_reqs.push_back(make_query(10, 11));
      pending_reqs.push_back(make_load(1022, 32'hAAAA_5555));
      pending_reqs.push_back(make_query(1022, 1021));
      drain_all();

      // Count extremes and middle values, each followed by random traffic.
      write_count(COUNT_W'(1));
      pending_reqs.push_back(make_query(0, 0));
      pending_reqs.push_back(make_query(12, 11));
      random_phase(150, 16);
      drain_all();
      write_count(COUNT_W'(13));
      pending_reqs.push_back(make_query(10, 11));
      pending_reqs.push_back(make_query(11, 12));
      random_phase(200, 20);
      // Once part of the traffic is out, pause until all answers are in,
      // then resume with the same count.
      wait (pending_reqs.size() <= 100);
      hold_for_drain = 1'b1;
      @(posedge clock);
      wait (expected_answers.size() == 0 && !start && !busy);
      hold_for_drain = 1'b0;
      drain_all();
      write_count(COUNT_W'(0));
      pending_reqs.push_back(make_query(10, 11));
      random_phase(150, 12);
      drain_all();
      write_count(COUNT_W'(2047));
      random_phase(300, 24);
      drain_all();
      write_count(COUNT_W'(1024));
      random_phase(250, 40);
      for (int i = 0; i < 20; i++)
         pending_reqs.push_back(make_query($urandom_range(1023, 0), $urandom_range(1023, 0)));
      drain_all();
      write_count(COUNT_W'($urandom_range(1023, 2)));
      random_phase(200, 30);
      drain_all();

      if (failures == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule
`default_nettype wire
